// ===== design/atd_pkg.sv =====
// Shared types and constants for the accelerometer tilt block.
// Holds the microcode program, control word layout, CORDIC widths and the arctangent table.
// No dependencies.
`default_nettype none

package atd_pkg;

  localparam int XY_W     = 28;
  localparam int ANG_W    = 27;
  localparam int ATAN_W   = 22;
  localparam int TAB_LEN  = 24;
  localparam int TAB_IDX_W = 5;
  localparam int PC_W     = 3;

  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [17:0]      GAIN_Q16   = 18'sd107922;

  typedef enum logic [2:0] {
    REG_DEADBAND     = 3'd0,
    REG_ROLL_SCALE   = 3'd1,
    REG_PITCH_SCALE  = 3'd2,
    REG_ROLL_CENTER  = 3'd3,
    REG_PITCH_CENTER = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_WAIT_IN,
    OP_ITER,
    OP_FIN_ROLL,
    OP_FIN_PITCH,
    OP_CMP,
    OP_POS,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_ITER_MORE,
    COND_NO_UPDATE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctrl_t;

  typedef struct packed {
    logic last;
  } cordic_stat_t;

  localparam logic [PC_W-1:0] PC_WAIT      = 3'd0;
  localparam logic [PC_W-1:0] PC_ITER_ROLL = 3'd1;
  localparam logic [PC_W-1:0] PC_FIN_ROLL  = 3'd2;
  localparam logic [PC_W-1:0] PC_ITER_PIT  = 3'd3;
  localparam logic [PC_W-1:0] PC_FIN_PIT   = 3'd4;
  localparam logic [PC_W-1:0] PC_CMP       = 3'd5;
  localparam logic [PC_W-1:0] PC_POS       = 3'd6;
  localparam logic [PC_W-1:0] PC_EMIT      = 3'd7;

  // The last step falls through to the first by counter wraparound.
  function automatic uword_t atd_ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_WAIT:      w = '{op: OP_WAIT_IN,   cond: COND_NO_INPUT,  target: PC_WAIT};
      PC_ITER_ROLL: w = '{op: OP_ITER,      cond: COND_ITER_MORE, target: PC_ITER_ROLL};
      PC_FIN_ROLL:  w = '{op: OP_FIN_ROLL,  cond: COND_NONE,      target: PC_WAIT};
      PC_ITER_PIT:  w = '{op: OP_ITER,      cond: COND_ITER_MORE, target: PC_ITER_PIT};
      PC_FIN_PIT:   w = '{op: OP_FIN_PITCH, cond: COND_NONE,      target: PC_WAIT};
      PC_CMP:       w = '{op: OP_CMP,       cond: COND_NO_UPDATE, target: PC_WAIT};
      PC_POS:       w = '{op: OP_POS,       cond: COND_NONE,      target: PC_WAIT};
      PC_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: PC_EMIT};
    endcase
    return w;
  endfunction

  function automatic logic [ATAN_W-1:0] atd_atan(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/accel_tilt_angle_deadband.sv =====
// Top level of the accelerometer tilt block: microcoded sequencer, register port and datapath.
// Depends on atd_pkg and atd_cordic.
//
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_ready_o    accel_x_i, accel_y_i, accel_z_i
//   output   out_valid_o / out_ready_i  roll_angle_o, pitch_angle_o, marker_column_o, marker_row_o
//   config   APB write/read             paddr, pwdata, prdata
//
// Each item runs two vectorings, roll then pitch, one after the other on the single shared
// CORDIC unit; an item dropped by the deadband returns to the wait step before the position
// and emit steps, and a new item is accepted only in the wait step.
// A result waits in the output register; a stalled output holds only the final step.
// Reset restores the register defaults and clears the stored angles.
`default_nettype none

module accel_tilt_angle_deadband
  import atd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [16:0]      roll_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic [6:0]              marker_column_o,
  output logic [5:0]              marker_row_o
);

  localparam logic signed [18:0] ROLL_LIM  = 19'sd46080;
  localparam logic signed [18:0] PITCH_LIM = 19'sd23040;
  localparam logic signed [14:0] COL_MAX   = 15'(SCREEN_WIDTH - 1);
  localparam logic signed [14:0] ROW_MAX   = 15'(SCREEN_HEIGHT - 1);

  function automatic logic signed [18:0] round_q88(input logic signed [ANG_W-1:0] v);
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] r;
    logic [18:0]      rr;
    mag = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
    r   = (mag + ANG_W'(128)) >> 8;
    rr  = r[18:0];
    return v[ANG_W-1] ? -$signed(rr) : $signed(rr);
  endfunction

  function automatic logic signed [18:0] clamp_sym(input logic signed [18:0] v,
                                                   input logic signed [18:0] lim);
    logic signed [18:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [14:0] marker_off(input logic signed [29:0] p);
    logic [29:0] mag;
    logic [14:0] off;
    mag = p[29] ? 30'(-p) : 30'(p);
    off = {1'b0, mag[29:16]};
    return p[29] ? -$signed(off) : $signed(off);
  endfunction

  function automatic logic signed [14:0] clamp_pos(input logic signed [14:0] v,
                                                   input logic signed [14:0] hi);
    logic signed [14:0] r;
    r = v;
    if (v < 15'sd0) r = 15'sd0;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] deadband_q;
  logic [11:0] roll_scale_q, pitch_scale_q;
  logic [6:0]  roll_center_q;
  logic [5:0]  pitch_center_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q     <= 16'd256;
      roll_scale_q   <= 12'd256;
      pitch_scale_q  <= 12'd256;
      roll_center_q  <= 7'd64;
      pitch_center_q <= 6'd42;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DEADBAND:     deadband_q     <= pwdata[15:0];
        REG_ROLL_SCALE:   roll_scale_q   <= pwdata[11:0];
        REG_PITCH_SCALE:  pitch_scale_q  <= pwdata[11:0];
        REG_ROLL_CENTER:  roll_center_q  <= pwdata[6:0];
        REG_PITCH_CENTER: pitch_center_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DEADBAND:     prdata = {16'd0, deadband_q};
      REG_ROLL_SCALE:   prdata = {20'd0, roll_scale_q};
      REG_PITCH_SCALE:  prdata = {20'd0, pitch_scale_q};
      REG_ROLL_CENTER:  prdata = {25'd0, roll_center_q};
      REG_PITCH_CENTER: prdata = {26'd0, pitch_center_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer.
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            jump;
  logic            in_fire;
  logic            update;
  logic            out_busy;
  cordic_ctrl_t    cctrl;
  cordic_stat_t    cstat;

  assign uw         = atd_ucode(pc_q);
  assign in_ready_o = (uw.op == OP_WAIT_IN);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_o && !out_ready_i;

  always_comb begin
    unique case (uw.cond)
      COND_NONE:      jump = 1'b0;
      COND_NO_INPUT:  jump = !in_valid_i;
      COND_ITER_MORE: jump = !cstat.last;
      COND_NO_UPDATE: jump = !update;
      COND_OUT_BUSY:  jump = out_busy;
      default:        jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Datapath.
  logic signed [XY_W-1:0]  load_x, load_y, mag;
  logic signed [ANG_W-1:0] angle;
  logic signed [18:0]      roll_rnd, pitch_rnd;
  logic signed [17:0]      nax;
  logic signed [35:0]      num_prod;
  logic signed [XY_W-1:0]  num_q;
  logic signed [16:0]      roll_q;
  logic signed [15:0]      pitch_q;
  logic signed [16:0]      held_roll_q;
  logic signed [15:0]      held_pitch_q;
  logic signed [17:0]      dr;
  logic signed [16:0]      dp;
  logic [17:0]             dr_abs;
  logic [16:0]             dp_abs;
  logic signed [29:0]      roll_prod_q, pitch_prod_q;
  logic signed [14:0]      col_pos, row_pos;
  logic [6:0]              col_q;
  logic [5:0]              row_q;
  logic                    emit;

  assign nax      = 18'sd0 - {{2{accel_x_i[15]}}, accel_x_i};
  assign num_prod = nax * GAIN_Q16;

  assign cctrl.load = in_fire || (uw.op == OP_FIN_ROLL);
  assign cctrl.step = (uw.op == OP_ITER);
  assign load_x = in_fire ? {{4{accel_z_i[15]}}, accel_z_i, 8'd0} : mag;
  assign load_y = in_fire ? {{4{accel_y_i[15]}}, accel_y_i, 8'd0} : num_q;

  atd_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cctrl),
    .load_x_i(load_x),
    .load_y_i(load_y),
    .stat_o  (cstat),
    .angle_o (angle),
    .mag_o   (mag)
  );

  assign roll_rnd  = clamp_sym(round_q88(angle), ROLL_LIM);
  assign pitch_rnd = clamp_sym(round_q88(angle), PITCH_LIM);

  assign dr     = {roll_q[16], roll_q} - {held_roll_q[16], held_roll_q};
  assign dp     = {pitch_q[15], pitch_q} - {held_pitch_q[15], held_pitch_q};
  assign dr_abs = dr[17] ? 18'(-dr) : 18'(dr);
  assign dp_abs = dp[16] ? 17'(-dp) : 17'(dp);
  assign update = (dr_abs > {2'd0, deadband_q}) || (dp_abs > {1'b0, deadband_q});

  assign col_pos = clamp_pos($signed({8'd0, roll_center_q}) + marker_off(roll_prod_q), COL_MAX);
  assign row_pos = clamp_pos($signed({9'd0, pitch_center_q}) + marker_off(pitch_prod_q),
                             ROW_MAX);

  assign emit = (uw.op == OP_EMIT) && !out_busy;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      num_q <= num_prod[35:8];
    end
    if (uw.op == OP_FIN_ROLL) begin
      roll_q <= roll_rnd[16:0];
    end
    if (uw.op == OP_FIN_PITCH) begin
      pitch_q <= pitch_rnd[15:0];
    end
    if (uw.op == OP_CMP) begin
      roll_prod_q  <= roll_q * $signed({1'b0, roll_scale_q});
      pitch_prod_q <= pitch_q * $signed({1'b0, pitch_scale_q});
    end
    if (uw.op == OP_POS) begin
      col_q <= col_pos[6:0];
      row_q <= row_pos[5:0];
    end
    if (emit) begin
      roll_angle_o    <= roll_q;
      pitch_angle_o   <= pitch_q;
      marker_column_o <= col_q;
      marker_row_o    <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o  <= 1'b0;
      held_roll_q  <= '0;
      held_pitch_q <= '0;
    end else begin
      if (emit) begin
        out_valid_o  <= 1'b1;
        held_roll_q  <= roll_q;
        held_pitch_q <= pitch_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/atd_cordic.sv =====
// Shared CORDIC vectoring unit, one micro-rotation per cycle.
// Load applies the half-turn pre-rotation and zero check; depends on atd_pkg.
`default_nettype none

module atd_cordic
  import atd_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cordic_ctrl_t            ctrl_i,
  input  wire logic signed [XY_W-1:0]  load_x_i,
  input  wire logic signed [XY_W-1:0]  load_y_i,
  output cordic_stat_t                 stat_o,
  output logic signed [ANG_W-1:0]      angle_o,
  output logic signed [XY_W-1:0]       mag_o
);

  localparam int unsigned N_STEPS = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
  localparam int unsigned CNT_W   = $clog2(N_STEPS);

  logic signed [XY_W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ANG_W-1:0] ang_q, ang_d;
  logic                    zero_q, zero_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    last;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] step_ang;

  assign last     = (cnt_q == CNT_W'(N_STEPS - 1));
  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign step_ang = $signed({{(ANG_W-ATAN_W){1'b0}}, atd_atan(TAB_IDX_W'(cnt_q))});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    ang_d  = ang_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    if (ctrl_i.load) begin
      cnt_d  = '0;
      zero_d = (load_x_i == '0) && (load_y_i == '0);
      if (load_x_i[XY_W-1]) begin
        x_d   = -load_x_i;
        y_d   = -load_y_i;
        ang_d = load_y_i[XY_W-1] ? -DEG180_Q16 : DEG180_Q16;
      end else begin
        x_d   = load_x_i;
        y_d   = load_y_i;
        ang_d = '0;
      end
    end else if (ctrl_i.step) begin
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
      if (!y_q[XY_W-1]) begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        ang_d = ang_q + step_ang;
      end else begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        ang_d = ang_q - step_ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    zero_q <= zero_d;
  end

  assign stat_o.last = last;
  assign angle_o     = zero_q ? '0 : ang_q;
  assign mag_o       = x_q;

endmodule

`default_nettype wire
